// ----- hw/rtl/oais_pkg.sv -----
package oais_pkg;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_SEARCH = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [31:0] MASK_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [5:0]  position;
		logic [31:0] element_value;
	} oais_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [5:0]  found_position;
		logic [31:0] read_value;
		logic [6:0]  element_count;
	} oais_out_t;

	// Broadcast to every cell; the shift flags are already qualified by a transfer.
	typedef struct packed {
		logic append;
		logic insert;
		logic remove;
		logic search;
	} oais_cmd_t;

endpackage

// ----- hw/rtl/oais_cell.sv -----
module oais_cell #(
	parameter int INDEX = 0,
	parameter int CW = 7,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                     clk,
	input  oais_pkg::oais_cmd_t      cmd,
	input  logic [CW-1:0]            pos,
	input  logic [CW-1:0]            count,
	input  logic [ELEMENT_WIDTH-1:0] value,
	input  logic [ELEMENT_WIDTH-1:0] mask,
	input  logic [ELEMENT_WIDTH-1:0] prev_elem,
	input  logic [ELEMENT_WIDTH-1:0] next_elem,
	output logic [ELEMENT_WIDTH-1:0] elem,
	output logic                     hit
);
	import oais_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic [ELEMENT_WIDTH-1:0] elem_q;
	logic [ELEMENT_WIDTH-1:0] elem_d;
	logic                     load;
	logic                     at_pos;
	logic                     above_pos;

	always_comb begin
		at_pos    = (MY_IDX == pos);
		above_pos = (MY_IDX > pos);
		load      = 1'b0;
		elem_d    = value;
		if (cmd.append && (MY_IDX == count)) begin
			load = 1'b1;
		end else if (cmd.insert && at_pos) begin
			load = 1'b1;
		end else if (cmd.insert && above_pos) begin
			load   = 1'b1;
			elem_d = prev_elem;
		end else if (cmd.remove && (at_pos || above_pos)) begin
			load   = 1'b1;
			elem_d = next_elem;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			elem_q <= elem_d;
		end
	end

	// A search hit needs an occupied cell; a read hit is the addressed cell.
	always_comb begin
		if (cmd.search) begin
			hit = (MY_IDX < count) && (((elem_q ^ value) & mask) == '0);
		end else begin
			hit = at_pos;
		end
	end

	assign elem = elem_q;

endmodule

// ----- hw/rtl/oais_tree.sv -----
module oais_tree #(
	parameter int CAPACITY = 64,
	parameter int ELEMENT_WIDTH = 32,
	parameter int IDX_W = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     hit [CAPACITY],
	input  logic [ELEMENT_WIDTH-1:0] elem [CAPACITY],
	output logic                     res_valid,
	output logic                     res_hit,
	output logic [IDX_W-1:0]         res_idx,
	output logic [ELEMENT_WIDTH-1:0] res_elem
);
	import oais_pkg::*;

	localparam int LEVELS = $clog2(CAPACITY);
	localparam int LEAVES = 1 << LEVELS;

	logic                     leaf_hit  [LEAVES];
	logic [ELEMENT_WIDTH-1:0] leaf_elem [LEAVES];

	// Heap order: node 1 is the root, the children of node k are 2k and 2k+1.
	logic                     node_hit_q  [1:2*LEAVES-1];
	logic [IDX_W-1:0]         node_idx_q  [1:2*LEAVES-1];
	logic [ELEMENT_WIDTH-1:0] node_elem_q [1:2*LEAVES-1];
	logic [LEVELS:0]          vld_q;

	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < CAPACITY) begin : g_used
			assign leaf_hit[j]  = hit[j];
			assign leaf_elem[j] = elem[j];
		end else begin : g_pad
			assign leaf_hit[j]  = 1'b0;
			assign leaf_elem[j] = '0;
		end
	end

	// The lower index wins, so the root holds the first hit.
	always_ff @(posedge clk) begin
		for (int j = 0; j < LEAVES; j++) begin
			node_hit_q[LEAVES+j]  <= leaf_hit[j];
			node_idx_q[LEAVES+j]  <= IDX_W'(j);
			node_elem_q[LEAVES+j] <= leaf_elem[j];
		end
		for (int k = 1; k < LEAVES; k++) begin
			node_hit_q[k] <= node_hit_q[2*k] || node_hit_q[2*k+1];
			if (node_hit_q[2*k]) begin
				node_idx_q[k]  <= node_idx_q[2*k];
				node_elem_q[k] <= node_elem_q[2*k];
			end else begin
				node_idx_q[k]  <= node_idx_q[2*k+1];
				node_elem_q[k] <= node_elem_q[2*k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LEVELS-1:0], start};
		end
	end

	assign res_valid = vld_q[LEVELS];
	assign res_hit   = node_hit_q[1];
	assign res_idx   = node_idx_q[1];
	assign res_elem  = node_elem_q[1];

endmodule

// ----- hw/rtl/ordered_array_insert_remove_search.sv -----
// Fixed-capacity element list held in a row of CAPACITY cells, one element per cell.
// Append writes the first free cell; insert and remove move every affected element
// one cell in the same clock, so they finish in the cycle after the transfer, and the
// next item may follow at once unless a result is already parked. A search, or a read
// in range, takes a snapshot of every cell's match flag and element into a registered
// priority tree that picks the lowest hit; no further transfer is taken until the
// tree's result has come out. A result waiting at the output does not hold up the
// next item: one further result is parked behind it. The compare mask may only be
// rewritten while idle.
module ordered_array_insert_remove_search #(
	parameter int CAPACITY = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [31:0]         cfg_write_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  oais_pkg::oais_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output oais_pkg::oais_out_t out_item
);
	import oais_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
	localparam int IDX_W = $clog2(CAPACITY);

	logic [31:0]      mask_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             busy_q;
	logic             search_q;
	logic             pend_valid_q;
	oais_out_t        pend_q;
	logic             out_valid_q;
	oais_out_t        out_q;

	logic             accept;
	logic [CW-1:0]    pos_w;
	logic [CW-1:0]    cnt_w;
	logic             full;
	logic [1:0]       status_d;
	logic             tree_start;
	oais_cmd_t        cmd;

	logic [ELEMENT_WIDTH-1:0] value_e;
	logic [ELEMENT_WIDTH-1:0] mask_e;
	logic [ELEMENT_WIDTH-1:0] elems [CAPACITY];
	logic                     hits  [CAPACITY];

	logic                     tree_valid;
	logic                     tree_hit;
	logic [IDX_W-1:0]         tree_idx;
	logic [ELEMENT_WIDTH-1:0] tree_elem;

	logic      res_valid;
	oais_out_t res;
	logic      out_load;

	assign in_ready = !busy_q && !pend_valid_q;
	assign accept   = in_valid && in_ready;
	assign pos_w    = CW'(in_item.position);
	assign cnt_w    = CW'(cnt_q);
	assign full     = (cnt_w >= CW'(CAPACITY));
	assign value_e  = ELEMENT_WIDTH'(in_item.element_value);
	assign mask_e   = ELEMENT_WIDTH'(mask_q);

	always_comb begin
		status_d   = ST_OK;
		cnt_d      = cnt_q;
		tree_start = 1'b0;
		cmd        = '0;
		cmd.search = (in_item.opcode == OP_SEARCH);
		unique case (in_item.opcode)
			OP_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.append = accept;
					cnt_d      = CNT_W'(cnt_q + 1'b1);
				end
			end
			OP_INSERT: begin
				// The range check comes before the fullness check.
				if (pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.insert = accept;
					cnt_d      = CNT_W'(cnt_q + 1'b1);
				end
			end
			OP_REMOVE: begin
				if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					cmd.remove = accept;
					cnt_d      = CNT_W'(cnt_q - 1'b1);
				end
			end
			OP_SEARCH: begin
				tree_start = accept;
			end
			OP_READ: begin
				if (pos_w >= cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					tree_start = accept;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] prev_elem;
		logic [ELEMENT_WIDTH-1:0] next_elem;

		if (i == 0) begin : g_first
			assign prev_elem = value_e;
		end else begin : g_prev
			assign prev_elem = elems[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_elem = elems[i];
		end else begin : g_next
			assign next_elem = elems[i+1];
		end

		oais_cell #(
			.INDEX         (i),
			.CW            (CW),
			.ELEMENT_WIDTH (ELEMENT_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (pos_w),
			.count     (cnt_w),
			.value     (value_e),
			.mask      (mask_e),
			.prev_elem (prev_elem),
			.next_elem (next_elem),
			.elem      (elems[i]),
			.hit       (hits[i])
		);
	end

	oais_tree #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH),
		.IDX_W         (IDX_W)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (tree_start),
		.hit       (hits),
		.elem      (elems),
		.res_valid (tree_valid),
		.res_hit   (tree_hit),
		.res_idx   (tree_idx),
		.res_elem  (tree_elem)
	);

	// Results come either straight from the transfer or from the tree, never both.
	always_comb begin
		res = '0;
		if (tree_valid) begin
			res_valid         = 1'b1;
			res.status        = ST_OK;
			res.found         = search_q && tree_hit;
			res.found_position = (search_q && tree_hit) ? 6'(tree_idx) : 6'd0;
			res.read_value    = search_q ? 32'd0 : 32'(tree_elem);
			res.element_count = 7'(cnt_q);
		end else begin
			res_valid         = accept && !tree_start;
			res.status        = status_d;
			res.element_count = 7'(cnt_d);
		end
	end

	assign out_load = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= MASK_RESET;
			cnt_q        <= '0;
			busy_q       <= 1'b0;
			search_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				mask_q <= cfg_write_data;
			end
			if (accept) begin
				cnt_q <= cnt_d;
			end
			if (tree_start) begin
				busy_q   <= 1'b1;
				search_q <= (in_item.opcode == OP_SEARCH);
			end else if (tree_valid) begin
				busy_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q  <= pend_valid_q || res_valid;
				pend_valid_q <= 1'b0;
			end else if (res_valid) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= pend_valid_q ? pend_q : res;
		end else if (res_valid) begin
			pend_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	a_tree_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tree_valid |-> busy_q)
		else $error("tree result without an outstanding search or read");

	a_no_result_collision: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !pend_valid_q)
		else $error("new result while one is already parked");

	a_count_stable_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> $stable(cnt_q))
		else $error("element count changed during a search or read");

endmodule
